### rtl/core/efr_pkg.sv
package efr_pkg;

    // Trig values are signed Q2.30, magnitudes never exceed 1.0
    localparam int TRIG_FRAC = 30;
    localparam int TRIG_W    = 32;
    localparam int MAG_W     = 31;
    localparam int X2_W      = 32;
    localparam int MAT_W     = 33;

    localparam logic [MAG_W-1:0] TRIG_ONE    = 31'h4000_0000;
    localparam logic [MAG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [63:0]      ROUND_Q30   = 64'd536870912;

    // Horner divisors 156, 110, 72, 42, 20, 6 as exact reciprocal multiplies
    // for a 32-bit dividend: q = (n * RECIP) >> SHIFT
    localparam int N_HORNER = 6;
    localparam int HORNER_SHIFT [N_HORNER] = '{40, 39, 39, 38, 37, 35};
    localparam logic [32:0] HORNER_RECIP [N_HORNER] = '{
        33'(((64'd1 << 40) + 64'd155) / 64'd156),
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 35) + 64'd5) / 64'd6)
    };

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [MAT_W-1:0]  t_mat;

    typedef struct packed {
        t_trig sin_v;
        t_trig cos_v;
    } t_sincos;

    // Q30 product, magnitude rounded half up, sign applied after
    function automatic t_trig mul_q30(input t_trig a, input t_trig b);
        logic             neg;
        logic [MAG_W-1:0] ua;
        logic [MAG_W-1:0] ub;
        logic [63:0]      prod;
        logic [MAG_W-1:0] mag;
        neg  = a[TRIG_W-1] ^ b[TRIG_W-1];
        ua   = a[TRIG_W-1] ? MAG_W'(-a) : MAG_W'(a);
        ub   = b[TRIG_W-1] ? MAG_W'(-b) : MAG_W'(b);
        prod = 64'(ua) * 64'(ub) + ROUND_Q30;
        mag  = MAG_W'(prod >> TRIG_FRAC);
        return neg ? -t_trig'({1'b0, mag}) : t_trig'({1'b0, mag});
    endfunction

endpackage

### rtl/core/efr_if.sv
interface efr_in_if #(
    parameter int VALUE_BITS = 32,
    parameter int ANGLE_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [VALUE_BITS-1:0] vec_x;
    logic signed [VALUE_BITS-1:0] vec_y;
    logic signed [VALUE_BITS-1:0] vec_z;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] heading_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;

    modport source (
        output valid, cmd, vec_x, vec_y, vec_z, pitch_angle, heading_angle, roll_angle,
        input  ready
    );
    modport sink (
        input  valid, cmd, vec_x, vec_y, vec_z, pitch_angle, heading_angle, roll_angle,
        output ready
    );
endinterface

interface efr_out_if #(
    parameter int VALUE_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] out_x;
    logic signed [VALUE_BITS-1:0] out_y;
    logic signed [VALUE_BITS-1:0] out_z;
    logic                         saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

### rtl/core/efr_horner_cell.sv
module efr_horner_cell
    import efr_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [MAG_W-1:0] i_x,
    input  logic [X2_W-1:0]  i_x2,
    input  logic [MAG_W-1:0] i_t,
    output logic [MAG_W-1:0] o_x,
    output logic [X2_W-1:0]  o_x2,
    output logic [MAG_W-1:0] o_t
);

    logic [MAG_W-1:0] r_x_a;
    logic [X2_W-1:0]  r_x2_a;
    logic [X2_W-1:0]  r_pr;
    logic [MAG_W-1:0] r_x_b;
    logic [X2_W-1:0]  r_x2_b;
    logic [MAG_W-1:0] r_t;
    logic [63:0]      n_prod;
    logic [X2_W-1:0]  n_pr;
    logic [64:0]      n_qfull;
    logic [MAG_W-1:0] n_t;

    // First half: x2 * t rounded back to Q30
    always_comb begin
        n_prod = 64'(i_x2) * 64'(i_t) + ROUND_Q30;
        n_pr   = X2_W'(n_prod >> TRIG_FRAC);
    end

    // Second half: divide by the step constant, subtract from one
    always_comb begin
        n_qfull = 65'(r_pr) * 65'(HORNER_RECIP[IDX]);
        n_t     = TRIG_ONE - MAG_W'(n_qfull >> HORNER_SHIFT[IDX]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_a  <= i_x;
            r_x2_a <= i_x2;
            r_pr   <= n_pr;
            r_x_b  <= r_x_a;
            r_x2_b <= r_x2_a;
            r_t    <= n_t;
        end
    end

    assign o_x  = r_x_b;
    assign o_x2 = r_x2_b;
    assign o_t  = r_t;

endmodule

### rtl/core/efr_quarter_sine.sv
module efr_quarter_sine
    import efr_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-2:0] i_m,
    output logic [MAG_W-1:0]      o_s
);

    localparam int XP_W = ANGLE_BITS - 1 + MAG_W;

    logic [XP_W-1:0]  n_mh;
    logic [MAG_W-1:0] r_x1;
    logic [MAG_W-1:0] r_x2_x;
    logic [X2_W-1:0]  r_x2;
    logic [63:0]      n_xx;
    logic [MAG_W-1:0] w_cx  [N_HORNER+1];
    logic [X2_W-1:0]  w_cx2 [N_HORNER+1];
    logic [MAG_W-1:0] w_ct  [N_HORNER+1];
    logic [63:0]      n_xt;
    logic [MAG_W-1:0] n_s;
    logic [MAG_W-1:0] r_s;

    // Scale the angle to radians in Q30
    assign n_mh = XP_W'(i_m) * XP_W'(HALF_PI_Q30)
                + (XP_W'(1) << (ANGLE_BITS - 3));
    // Square of the radian value
    assign n_xx = 64'(r_x1) * 64'(r_x1) + ROUND_Q30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= MAG_W'(n_mh >> (ANGLE_BITS - 2));
            r_x2_x <= r_x1;
            r_x2   <= X2_W'(n_xx >> TRIG_FRAC);
        end
    end

    // Horner chain, one cell per series term
    assign w_cx[0]  = r_x2_x;
    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = TRIG_ONE;

    for (genvar k = 0; k < N_HORNER; k++) begin : g_cell
        efr_horner_cell #(.IDX(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_cx[k]),
            .i_x2  (w_cx2[k]),
            .i_t   (w_ct[k]),
            .o_x   (w_cx[k+1]),
            .o_x2  (w_cx2[k+1]),
            .o_t   (w_ct[k+1])
        );
    end

    // Final product, clip at one
    always_comb begin
        n_xt = 64'(w_cx[N_HORNER]) * 64'(w_ct[N_HORNER]) + ROUND_Q30;
        n_s  = (n_xt[63:TRIG_FRAC] > 34'(TRIG_ONE)) ? TRIG_ONE : MAG_W'(n_xt >> TRIG_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

### rtl/core/efr_dcm_rotate.sv
module efr_dcm_rotate
    import efr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  t_sincos                      i_pitch,
    input  t_sincos                      i_yaw,
    input  t_sincos                      i_roll,
    input  logic                         i_cmd,
    input  logic [VALUE_BITS-1:0]        i_vec_x,
    input  logic [VALUE_BITS-1:0]        i_vec_y,
    input  logic [VALUE_BITS-1:0]        i_vec_z,
    output logic signed [VALUE_BITS-1:0] o_x,
    output logic signed [VALUE_BITS-1:0] o_y,
    output logic signed [VALUE_BITS-1:0] o_z,
    output logic                         o_sat
);

    localparam int LO_W  = VALUE_BITS / 2;
    localparam int HI_W  = VALUE_BITS - LO_W;
    localparam int LP_W  = MAT_W + LO_W + 1;
    localparam int HP_W  = MAT_W + HI_W;
    localparam int SL_W  = LP_W + 2;
    localparam int SH_W  = HP_W + 2;
    localparam int TOT_W = SH_W + LO_W + 1;
    localparam int RES_W = TOT_W - TRIG_FRAC;
    localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(64'sd536870912);
    localparam logic signed [RES_W-1:0] RES_MAX =
        RES_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

    t_trig r_ctcp, r_ctsp, r_stsf, r_stcf, r_stsp, r_spcf, r_cfcp;
    t_trig r_sfct, r_sfsp, r_sfcp, r_ctcf, r_nst, r_cp, r_sp, r_cf;
    t_trig r2_ctcp, r2_ctsp, r2_nst, r2_spcf, r2_cfcp, r2_sfct, r2_sfsp;
    t_trig r2_sfcp, r2_ctcf, r2_stsfcp, r2_stsfsp, r2_stcfcp, r2_stspcf;
    t_mat  w_m   [3][3];
    t_mat  r_row [3][3];
    logic  [VALUE_BITS-1:0]   w_vec [3];
    logic signed [LO_W:0]     w_vl  [3];
    logic signed [HI_W-1:0]   w_vh  [3];
    logic signed [LP_W-1:0]   r_plo [3][3];
    logic signed [HP_W-1:0]   r_phi [3][3];
    logic signed [SL_W-1:0]   r_slo [3];
    logic signed [SH_W-1:0]   r_shi [3];
    logic signed [TOT_W-1:0]  w_tot [3];
    logic signed [RES_W-1:0]  w_res [3];
    logic [VALUE_BITS-1:0]    n_out [3];
    logic [2:0]               n_clip;
    logic [VALUE_BITS-1:0]    r_out [3];
    logic                     r_sat;

    // First products of the sine and cosine pairs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctcp <= mul_q30(i_pitch.cos_v, i_yaw.cos_v);
            r_ctsp <= mul_q30(i_pitch.cos_v, i_yaw.sin_v);
            r_stsf <= mul_q30(i_pitch.sin_v, i_roll.sin_v);
            r_stcf <= mul_q30(i_pitch.sin_v, i_roll.cos_v);
            r_stsp <= mul_q30(i_pitch.sin_v, i_yaw.sin_v);
            r_spcf <= mul_q30(i_yaw.sin_v, i_roll.cos_v);
            r_cfcp <= mul_q30(i_roll.cos_v, i_yaw.cos_v);
            r_sfct <= mul_q30(i_roll.sin_v, i_pitch.cos_v);
            r_sfsp <= mul_q30(i_roll.sin_v, i_yaw.sin_v);
            r_sfcp <= mul_q30(i_roll.sin_v, i_yaw.cos_v);
            r_ctcf <= mul_q30(i_pitch.cos_v, i_roll.cos_v);
            r_nst  <= -i_pitch.sin_v;
            r_cp   <= i_yaw.cos_v;
            r_sp   <= i_yaw.sin_v;
            r_cf   <= i_roll.cos_v;
        end
    end

    // Triple products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_stsfcp <= mul_q30(r_stsf, r_cp);
            r2_stsfsp <= mul_q30(r_stsf, r_sp);
            r2_stcfcp <= mul_q30(r_stcf, r_cp);
            r2_stspcf <= mul_q30(r_stsp, r_cf);
            r2_ctcp   <= r_ctcp;
            r2_ctsp   <= r_ctsp;
            r2_nst    <= r_nst;
            r2_spcf   <= r_spcf;
            r2_cfcp   <= r_cfcp;
            r2_sfct   <= r_sfct;
            r2_sfsp   <= r_sfsp;
            r2_sfcp   <= r_sfcp;
            r2_ctcf   <= r_ctcf;
        end
    end

    // Assemble the matrix
    always_comb begin
        w_m[0][0] = t_mat'(r2_ctcp);
        w_m[0][1] = t_mat'(r2_ctsp);
        w_m[0][2] = t_mat'(r2_nst);
        w_m[1][0] = t_mat'(r2_stsfcp) - t_mat'(r2_spcf);
        w_m[1][1] = t_mat'(r2_stsfsp) + t_mat'(r2_cfcp);
        w_m[1][2] = t_mat'(r2_sfct);
        w_m[2][0] = t_mat'(r2_stcfcp) + t_mat'(r2_sfsp);
        w_m[2][1] = t_mat'(r2_stspcf) - t_mat'(r2_sfcp);
        w_m[2][2] = t_mat'(r2_ctcf);
    end

    // Pick rows, transposed for earth to body
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_row[r][c] <= i_cmd ? w_m[c][r] : w_m[r][c];
                end
            end
        end
    end

    // Split each component into a signed high part and an unsigned low part
    assign w_vec[0] = i_vec_x;
    assign w_vec[1] = i_vec_y;
    assign w_vec[2] = i_vec_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_vl[c] = $signed({1'b0, w_vec[c][LO_W-1:0]});
            w_vh[c] = $signed(w_vec[c][VALUE_BITS-1:LO_W]);
        end
    end

    // Partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_plo[r][c] <= LP_W'(r_row[r][c]) * LP_W'(w_vl[c]);
                    r_phi[r][c] <= HP_W'(r_row[r][c]) * HP_W'(w_vh[c]);
                end
            end
        end
    end

    // Row sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_slo[r] <= SL_W'(r_plo[r][0]) + SL_W'(r_plo[r][1]) + SL_W'(r_plo[r][2]);
                r_shi[r] <= SH_W'(r_phi[r][0]) + SH_W'(r_phi[r][1]) + SH_W'(r_phi[r][2]);
            end
        end
    end

    // Merge halves, round to Q.16 and clip
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_tot[r] = (TOT_W'(r_shi[r]) <<< LO_W) + TOT_W'(r_slo[r]) + ROUND_HALF;
            w_res[r] = $signed(w_tot[r][TOT_W-1:TRIG_FRAC]);
            if (w_res[r] > RES_MAX) begin
                n_out[r]  = VALUE_BITS'(RES_MAX);
                n_clip[r] = 1'b1;
            end else if (w_res[r] < RES_MIN) begin
                n_out[r]  = VALUE_BITS'(RES_MIN);
                n_clip[r] = 1'b1;
            end else begin
                n_out[r]  = VALUE_BITS'(w_res[r]);
                n_clip[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_out[r] <= n_out[r];
            end
            r_sat <= |n_clip;
        end
    end

    assign o_x   = $signed(r_out[0]);
    assign o_y   = $signed(r_out[1]);
    assign o_z   = $signed(r_out[2]);
    assign o_sat = r_sat;

endmodule

### rtl/core/euler_frame_rotation.sv
// Euler angle (Z-Y-X) frame rotation of one Q.16 vector per request.
//
// Input channel i_req carries cmd, the vector and pitch, yaw and roll as
// binary angles (a full turn wraps at 2^ANGLE_BITS). cmd 0 rotates body to
// earth, cmd 1 applies the transposed matrix (earth to body). Output channel
// o_rsp carries the rotated vector and a flag set when any component clipped.
// Both channels move a request when valid and ready are high at a clock edge.
//
// Throughput: one request per cycle while the skid register is empty. The
// pipeline depth is set by the sine evaluation (a chain of six two-stage
// Horner cells per sine) followed by three matrix stages and three
// dot-product stages.
//
// Reset (synchronous, active low) empties the pipeline and output stage.
// When the receiver stalls, one more result is caught in a skid register;
// with both output registers full the pipeline freezes and i_req.ready drops
// until the receiver takes a result. No result is lost or repeated.
module euler_frame_rotation
    import efr_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efr_in_if.sink    i_req,
    efr_out_if.source o_rsp
);

    localparam int NST  = 23;
    localparam int SB_N = 20;
    localparam int S_SIN  = 15;
    localparam int S_CMD  = 18;
    localparam int S_VEC  = 19;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    localparam logic [ANGLE_BITS-2:0] QUARTER = {1'b1, {(ANGLE_BITS-2){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef struct packed {
        logic                  cmd;
        logic [VALUE_BITS-1:0] vx;
        logic [VALUE_BITS-1:0] vy;
        logic [VALUE_BITS-1:0] vz;
        logic [2:0][1:0]       quad;
    } t_side;

    typedef struct packed {
        logic [VALUE_BITS-1:0] x;
        logic [VALUE_BITS-1:0] y;
        logic [VALUE_BITS-1:0] z;
        logic                  sat;
    } t_result;

    logic                  w_en;
    logic [NST-1:0]        r_v;
    t_side                 r_sb  [SB_N];
    logic [ANGLE_BITS-1:0] r_ang [3];
    logic [ANGLE_BITS-2:0] w_m   [6];
    logic [MAG_W-1:0]      w_s   [6];
    t_sincos               n_trig [3];
    t_sincos               r_trig [3];
    t_trig                 w_sr;
    t_trig                 w_cr;
    logic signed [VALUE_BITS-1:0] w_px;
    logic signed [VALUE_BITS-1:0] w_py;
    logic signed [VALUE_BITS-1:0] w_pz;
    logic                  w_psat;
    t_result               w_pipe;
    t_result               r_out;
    t_result               r_skid;
    logic                  r_out_v;
    logic                  r_skid_v;

    // Pipeline moves unless the skid register holds a result
    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NST-2:0], i_req.valid};
        end
    end

    // Capture the request, shift side data along the pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0].cmd     <= i_req.cmd;
            r_sb[0].vx      <= i_req.vec_x;
            r_sb[0].vy      <= i_req.vec_y;
            r_sb[0].vz      <= i_req.vec_z;
            r_sb[0].quad[0] <= i_req.pitch_angle[ANGLE_BITS-1 -: 2];
            r_sb[0].quad[1] <= i_req.heading_angle[ANGLE_BITS-1 -: 2];
            r_sb[0].quad[2] <= i_req.roll_angle[ANGLE_BITS-1 -: 2];
            r_ang[0]        <= i_req.pitch_angle;
            r_ang[1]        <= i_req.heading_angle;
            r_ang[2]        <= i_req.roll_angle;
            for (int i = 1; i < SB_N; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    // Quarter-wave arguments: remainder and its complement
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_m[2*a]   = {1'b0, r_ang[a][ANGLE_BITS-3:0]};
            w_m[2*a+1] = QUARTER - {1'b0, r_ang[a][ANGLE_BITS-3:0]};
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_sine
        efr_quarter_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sine (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_m   (w_m[g]),
            .o_s   (w_s[g])
        );
    end

    // Fold the quadrant into sine and cosine
    always_comb begin
        w_sr = '0;
        w_cr = '0;
        for (int a = 0; a < 3; a++) begin
            w_sr = t_trig'({1'b0, w_s[2*a]});
            w_cr = t_trig'({1'b0, w_s[2*a+1]});
            case (r_sb[S_SIN].quad[a])
                QUAD_I: begin
                    n_trig[a].sin_v = w_sr;
                    n_trig[a].cos_v = w_cr;
                end
                QUAD_II: begin
                    n_trig[a].sin_v = w_cr;
                    n_trig[a].cos_v = -w_sr;
                end
                QUAD_III: begin
                    n_trig[a].sin_v = -w_sr;
                    n_trig[a].cos_v = -w_cr;
                end
                QUAD_IV: begin
                    n_trig[a].sin_v = -w_cr;
                    n_trig[a].cos_v = w_sr;
                end
                default: begin
                    n_trig[a].sin_v = w_sr;
                    n_trig[a].cos_v = w_cr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_trig[a] <= n_trig[a];
            end
        end
    end

    efr_dcm_rotate #(.VALUE_BITS(VALUE_BITS)) u_dcm (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pitch (r_trig[0]),
        .i_yaw   (r_trig[1]),
        .i_roll  (r_trig[2]),
        .i_cmd   (r_sb[S_CMD].cmd),
        .i_vec_x (r_sb[S_VEC].vx),
        .i_vec_y (r_sb[S_VEC].vy),
        .i_vec_z (r_sb[S_VEC].vz),
        .o_x     (w_px),
        .o_y     (w_py),
        .o_z     (w_pz),
        .o_sat   (w_psat)
    );

    assign w_pipe = '{x: w_px, y: w_py, z: w_pz, sat: w_psat};

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_rsp.ready) begin
            r_out_v  <= r_skid_v || (w_en && r_v[NST-1]);
            r_skid_v <= 1'b0;
        end else if (w_en && r_v[NST-1]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_rsp.ready) begin
            r_out <= r_skid_v ? r_skid : w_pipe;
        end else if (w_en && r_v[NST-1]) begin
            r_skid <= w_pipe;
        end
    end

    assign o_rsp.valid     = r_out_v;
    assign o_rsp.out_x     = $signed(r_out.x);
    assign o_rsp.out_y     = $signed(r_out.y);
    assign o_rsp.out_z     = $signed(r_out.z);
    assign o_rsp.saturated = r_out.sat;

    // The skid entry is only ever filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid with empty output register");

    // A full skid entry freezes the pipeline
    a_freeze_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_v))
        else $error("pipeline advanced while skid entry was full");

    // A clipped result has at least one component at a range end
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.sat) |->
            ($signed(r_out.x) == VAL_MAX || $signed(r_out.x) == VAL_MIN ||
             $signed(r_out.y) == VAL_MAX || $signed(r_out.y) == VAL_MIN ||
             $signed(r_out.z) == VAL_MAX || $signed(r_out.z) == VAL_MIN))
        else $error("saturation flag set without a clipped component");

endmodule

### test/euler_frame_rotation_tb.sv
module euler_frame_rotation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = 32;
    localparam int ANGLE_BITS = 16;
    localparam int LATENCY    = 23;
    localparam int N_RANDOM   = 740;
    localparam int LIMIT      = 400000;

    localparam logic CMD_B2E = 1'b0;
    localparam logic CMD_E2B = 1'b1;

    typedef logic signed [VALUE_BITS-1:0] t_val;
    typedef logic signed [ANGLE_BITS-1:0] t_ang;

    typedef struct {
        logic cmd;
        t_val vx;
        t_val vy;
        t_val vz;
        t_ang pitch;
        t_ang yaw;
        t_ang roll;
    } t_request;

    typedef struct {
        t_val ox;
        t_val oy;
        t_val oz;
        logic sat;
    } t_rotated;

    // directed row: request plus optional typed-in result
    typedef struct {
        t_request req;
        logic     has_fixed;
        t_rotated fixed;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    efr_in_if  #(.VALUE_BITS(VALUE_BITS), .ANGLE_BITS(ANGLE_BITS)) req_if ();
    efr_out_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();

    euler_frame_rotation #(.VALUE_BITS(VALUE_BITS), .ANGLE_BITS(ANGLE_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_rotated rotated_q [$];
    int       fail_cnt;
    int       cycle_cnt;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_off;
    logic     stim_done;

    // clock generation
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // quarter-wave sine of remainder m, Q30
    function automatic longint quarter_sine(input longint m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        x  = (longint'(m) * 64'd1686629713 + (64'd1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < 6; k++)
            t = (64'd1 << 30) - (((x2 * t + (64'd1 << 29)) >> 30) / divs[k]);
        s = (x * t + (64'd1 << 29)) >> 30;
        if (s > (64'd1 << 30))
            s = 64'd1 << 30;
        return longint'(s);
    endfunction

    function automatic void angle_trig(input t_ang ang, output longint s, output longint c);
        logic [ANGLE_BITS-1:0] a;
        longint                r;
        longint                sr;
        longint                cr;
        a  = ang;
        r  = longint'(a[ANGLE_BITS-3:0]);
        sr = quarter_sine(r);
        cr = quarter_sine((longint'(1) << (ANGLE_BITS - 2)) - r);
        case (a[ANGLE_BITS-1:ANGLE_BITS-2])
            2'd0: begin s = sr;  c = cr;  end
            2'd1: begin s = cr;  c = -sr; end
            2'd2: begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr; end
        endcase
    endfunction

    function automatic longint trig_mul(input longint a, input longint b);
        longint unsigned mag;
        mag = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    // exact dot product rounded half toward plus infinity, saturated
    function automatic t_val row_dot(input longint m0, input longint m1, input longint m2,
                                     input t_val v0, input t_val v1, input t_val v2,
                                     inout logic sat);
        logic signed [127:0] acc;
        logic signed [127:0] q;
        acc = 128'(m0) * 128'(v0) + 128'(m1) * 128'(v1) + 128'(m2) * 128'(v2);
        q   = (acc + (128'sd1 <<< 29)) >>> 30;
        if (q > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (q < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return t_val'(q);
    endfunction

    function automatic t_rotated rotate_vector(input t_request rq);
        longint   st, ct, sp, cp, sf, cf;
        longint   m [3][3];
        t_rotated res;
        logic     sat;
        angle_trig(rq.pitch, st, ct);
        angle_trig(rq.yaw, sp, cp);
        angle_trig(rq.roll, sf, cf);
        m[0][0] = trig_mul(ct, cp);
        m[0][1] = trig_mul(ct, sp);
        m[0][2] = -st;
        m[1][0] = trig_mul(trig_mul(st, sf), cp) - trig_mul(sp, cf);
        m[1][1] = trig_mul(trig_mul(st, sf), sp) + trig_mul(cf, cp);
        m[1][2] = trig_mul(sf, ct);
        m[2][0] = trig_mul(trig_mul(st, cf), cp) + trig_mul(sf, sp);
        m[2][1] = trig_mul(trig_mul(st, sp), cf) - trig_mul(sf, cp);
        m[2][2] = trig_mul(ct, cf);
        sat = 1'b0;
        if (rq.cmd == CMD_E2B) begin
            res.ox = row_dot(m[0][0], m[1][0], m[2][0], rq.vx, rq.vy, rq.vz, sat);
            res.oy = row_dot(m[0][1], m[1][1], m[2][1], rq.vx, rq.vy, rq.vz, sat);
            res.oz = row_dot(m[0][2], m[1][2], m[2][2], rq.vx, rq.vy, rq.vz, sat);
        end else begin
            res.ox = row_dot(m[0][0], m[0][1], m[0][2], rq.vx, rq.vy, rq.vz, sat);
            res.oy = row_dot(m[1][0], m[1][1], m[1][2], rq.vx, rq.vy, rq.vz, sat);
            res.oz = row_dot(m[2][0], m[2][1], m[2][2], rq.vx, rq.vy, rq.vz, sat);
        end
        res.sat = sat;
        return res;
    endfunction

    function automatic t_request make_req(input logic c, input t_val x, input t_val y,
                                          input t_val z, input t_ang p, input t_ang w,
                                          input t_ang r);
        t_request rq;
        rq.cmd = c; rq.vx = x; rq.vy = y; rq.vz = z;
        rq.pitch = p; rq.yaw = w; rq.roll = r;
        return rq;
    endfunction

    function automatic t_val rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return t_val'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return t_val'($urandom);
        endcase
    endfunction

    function automatic t_ang rand_ang();
        case ($urandom_range(0, 7))
            0: return t_ang'(16'h4000 * $urandom_range(0, 3));
            1: return t_ang'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
            default: return t_ang'($urandom);
        endcase
    endfunction

    // offer one request, idle at random, wait for acceptance
    task automatic send_request(input t_request rq);
        while ((send_idle_pct > 0) && ($urandom_range(0, 99) < send_idle_pct)) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= rq.cmd;
        req_if.vec_x         <= rq.vx;
        req_if.vec_y         <= rq.vy;
        req_if.vec_z         <= rq.vz;
        req_if.pitch_angle   <= rq.pitch;
        req_if.heading_angle <= rq.yaw;
        req_if.roll_angle    <= rq.roll;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain_wait();
        req_if.valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_row     rows [$];
        t_row     rw;
        t_rotated zero_res;
        t_request rq;
        int       k;

        req_if.valid         = 1'b0;
        req_if.cmd           = 1'b0;
        req_if.vec_x         = '0;
        req_if.vec_y         = '0;
        req_if.vec_z         = '0;
        req_if.pitch_angle   = '0;
        req_if.heading_angle = '0;
        req_if.roll_angle    = '0;
        i_rst_n            = 1'b0;
        stim_done          = 1'b0;
        send_idle_pct      = 12;
        recv_idle_pct      = 82;
        hold_off           = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        zero_res = '{ox: '0, oy: '0, oz: '0, sat: 1'b0};
        // zero vector: zero result, no clipping
        rw.has_fixed = 1'b1;
        rw.fixed     = zero_res;
        rw.req       = make_req(CMD_B2E, 0, 0, 0, 16'sh1234, -16'sh0777, 16'sh7fff);
        rows.push_back(rw);
        rw.req = make_req(CMD_E2B, 0, 0, 0, -16'sh8000, 16'sh4000, 16'sh0001);
        rows.push_back(rw);
        // identity rotation
        rw.req   = make_req(CMD_B2E, 32'sh0001_0000, -32'sh0002_0000, 32'sh7fff_ffff, 0, 0, 0);
        rw.fixed = '{ox: 32'sh0001_0000, oy: -32'sh0002_0000, oz: 32'sh7fff_ffff, sat: 1'b0};
        rows.push_back(rw);
        rw.req.cmd = CMD_E2B;
        rows.push_back(rw);
        rw.req   = make_req(CMD_B2E, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0);
        rw.fixed = '{ox: 32'sh8000_0000, oy: 32'sh8000_0000, oz: 32'sh7fff_ffff, sat: 1'b0};
        rows.push_back(rw);
        // predictor-checked rows: quadrants, extremes, clipping
        rw.has_fixed = 1'b0;
        rows.push_back('{make_req(CMD_B2E, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                  16'sh2000, 16'sh2000, 16'sh2000), 1'b0, zero_res});
        rows.push_back('{make_req(CMD_E2B, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                  16'sh2000, 16'sh2000, 16'sh2000), 1'b0, zero_res});
        rows.push_back('{make_req(CMD_B2E, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                  -16'sh2000, 16'sh6000, -16'sh6000), 1'b0, zero_res});
        rows.push_back('{make_req(CMD_B2E, 32'sh8000_0000, 0, 0, -16'sh8000, 0, 0),
                         1'b0, zero_res});
        rows.push_back('{make_req(CMD_E2B, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 16'sh4000, 0),
                         1'b0, zero_res});
        for (k = 0; k < 4; k++) begin
            rows.push_back('{make_req(CMD_B2E, 32'sh0001_0000, 32'sh0003_0000, -32'sh0005_0000,
                                      t_ang'(16'h4000 * k), 0, 0), 1'b0, zero_res});
            rows.push_back('{make_req(CMD_E2B, 32'sh0001_0000, 32'sh0003_0000, -32'sh0005_0000,
                                      0, t_ang'(16'h4000 * k + 1), t_ang'(16'h4000 * k - 1)),
                             1'b0, zero_res});
        end
        rows.push_back('{make_req(CMD_B2E, -1, 1, -1, 16'sh7fff, -16'sh8000, 16'sh7fff),
                         1'b0, zero_res});
        rows.push_back('{make_req(CMD_E2B, 32'sh5555_aaaa, -32'sh2aaa_5555, 32'sh0f0f_f0f0,
                                  16'sh5a5a, -16'sh5a5b, 16'sh0f0f), 1'b0, zero_res});

        foreach (rows[i]) begin
            rotated_q.push_back(rows[i].has_fixed ? rows[i].fixed : rotate_vector(rows[i].req));
            send_request(rows[i].req);
        end

        // random part with three idling phases
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                send_idle_pct = 82;
                recv_idle_pct = 12;
            end
            if (k == 2 * N_RANDOM / 3) begin
                // pause until all results have come
                drain_wait();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off      = 80;
            end
            rq = make_req($urandom_range(0, 1), rand_val(), rand_val(), rand_val(),
                          rand_ang(), rand_ang(), rand_ang());
            rotated_q.push_back(rotate_vector(rq));
            send_request(rq);
        end
        req_if.valid <= 1'b0;
        stim_done    <= 1'b1;
    end

    // receiver: random stalls and one long hold-off
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                rsp_if.ready <= 1'b0;
                hold_off     <= hold_off - 1;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_rotated exp_res;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rotated_q.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d", rsp_if.out_x, rsp_if.out_y,
                       rsp_if.out_z);
                fail_cnt++;
            end else begin
                exp_res = rotated_q.pop_front();
                if (rsp_if.out_x !== exp_res.ox) begin
                    $error("out_x expected %0d actual %0d", exp_res.ox, rsp_if.out_x);
                    fail_cnt++;
                end
                if (rsp_if.out_y !== exp_res.oy) begin
                    $error("out_y expected %0d actual %0d", exp_res.oy, rsp_if.out_y);
                    fail_cnt++;
                end
                if (rsp_if.out_z !== exp_res.oz) begin
                    $error("out_z expected %0d actual %0d", exp_res.oz, rsp_if.out_z);
                    fail_cnt++;
                end
                if (rsp_if.saturated !== exp_res.sat) begin
                    $error("saturated expected %0d actual %0d", exp_res.sat,
                           rsp_if.saturated);
                    fail_cnt++;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        fail_cnt  = 0;
        cycle_cnt = 0;
        fork
            begin
                wait (stim_done === 1'b1);
                while (rotated_q.size() != 0)
                    @(posedge i_clk);
                repeat (LATENCY * 2) @(posedge i_clk);
                if (rotated_q.size() != 0)
                    fail_cnt++;
                if (fail_cnt == 0)
                    $display("TB_OK");
                else
                    $display("TB_ERROR");
            end
            begin
                while (cycle_cnt < LIMIT) begin
                    @(posedge i_clk);
                    cycle_cnt++;
                end
                $display("TB_ERROR");
            end
        join_any
        $finish;
    end

endmodule
